// ===== design/mve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve_pkg
// shared codes, header bytes and the command type of the value encoder
// ----------------------------------------------------------------------------
package mve_pkg;

    localparam int ACT_W = 4;

    localparam logic [ACT_W-1:0] ACT_NIL   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_BOOL  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INT   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_UINT  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_F32   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_F64   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_STR   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ARRAY = 4'd7;
    localparam logic [ACT_W-1:0] ACT_MAP   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_RAW   = 4'd9;

    localparam logic [7:0] HDR_NIL    = 8'hc0;
    localparam logic [7:0] HDR_FALSE  = 8'hc2;
    localparam logic [7:0] HDR_TRUE   = 8'hc3;
    localparam logic [7:0] HDR_U8     = 8'hcc;
    localparam logic [7:0] HDR_U16    = 8'hcd;
    localparam logic [7:0] HDR_U32    = 8'hce;
    localparam logic [7:0] HDR_U64    = 8'hcf;
    localparam logic [7:0] HDR_F32    = 8'hca;
    localparam logic [7:0] HDR_F64    = 8'hcb;
    localparam logic [7:0] HDR_I8     = 8'hd0;
    localparam logic [7:0] HDR_I16    = 8'hd1;
    localparam logic [7:0] HDR_I32    = 8'hd2;
    localparam logic [7:0] HDR_I64    = 8'hd3;
    localparam logic [7:0] HDR_STR8   = 8'hd9;
    localparam logic [7:0] HDR_STR16  = 8'hda;
    localparam logic [7:0] HDR_STR32  = 8'hdb;
    localparam logic [7:0] HDR_ARR16  = 8'hdc;
    localparam logic [7:0] HDR_ARR32  = 8'hdd;
    localparam logic [7:0] HDR_MAP16  = 8'hde;
    localparam logic [7:0] HDR_MAP32  = 8'hdf;
    localparam logic [7:0] FIX_STR    = 8'ha0;
    localparam logic [7:0] FIX_ARRAY  = 8'h90;
    localparam logic [7:0] FIX_MAP    = 8'h80;

    localparam int SH_W  = 72;
    localparam int REM_W = 4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // header byte on top, payload bytes below it, msb first
    typedef struct packed {
        logic [SH_W-1:0]  sh;
        logic [REM_W-1:0] rem;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/mve_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve channel interfaces
// typed value input channel and encoded byte output channel
// ----------------------------------------------------------------------------
interface mve_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [63:0] value;
    logic        flag;
    logic [31:0] count;
    logic [7:0]  payload_byte;

    modport source (output valid, action, value, flag, count, payload_byte, input ready);
    modport sink   (input valid, action, value, flag, count, payload_byte, output ready);
endinterface

interface mve_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== design/msgpack_value_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_value_encoder_core
// MessagePack encoder for one typed value per input beat
// ----------------------------------------------------------------------------
// Each accepted value comes out as its MessagePack byte run, msb first, with
// last on the final byte; unused action codes give no bytes. The output runs
// at one byte per cycle while the sink holds ready, set by the serializer that
// shifts a command out one byte at a time; an item is 1 to 9 bytes long, and
// single-byte items stream at one per cycle too. A four-entry command queue sits
// between classifier and serializer; an accepted item passes through the queue
// entry, the shift register and the output register before its first byte shows.
module msgpack_value_encoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mve_in_if.sink     i_in,
    mve_out_if.source  o_out
);
    import mve_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_cmd f_cmd;
    t_cmd q_cmd;

    mve_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (f_cmd)
    );

    mve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mve_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== design/mve_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve_front
// accepts typed values and picks the encoding class of each one
// ----------------------------------------------------------------------------
module mve_front (
    mve_in_if.sink        i_in,
    input  wire logic     i_full,
    output logic          o_push,
    output mve_pkg::t_cmd o_cmd
);
    import mve_pkg::*;

    logic [7:0]       head;
    logic [63:0]      data;
    logic [REM_W-1:0] nb;
    logic [63:0]      aligned;
    logic [63:0]      v;
    logic [31:0]      c;

    assign v = i_in.value;
    assign c = i_in.count;

    always_comb begin
        head = 8'h00;
        data = 64'd0;
        nb   = REM_W'(0);
        case (i_in.action)
            ACT_NIL: begin
                head = HDR_NIL;
            end
            ACT_BOOL: begin
                head = i_in.flag ? HDR_TRUE : HDR_FALSE;
            end
            ACT_INT, ACT_UINT: begin
                data = v;
                if (i_in.action == ACT_INT && v[63]) begin
                    if (&v[63:5]) begin
                        head = v[7:0];
                    end else if (&v[63:7]) begin
                        head = HDR_I8;
                        nb   = REM_W'(1);
                    end else if (&v[63:15]) begin
                        head = HDR_I16;
                        nb   = REM_W'(2);
                    end else if (&v[63:31]) begin
                        head = HDR_I32;
                        nb   = REM_W'(4);
                    end else begin
                        head = HDR_I64;
                        nb   = REM_W'(8);
                    end
                end else begin
                    if (v[63:7] == '0) begin
                        head = v[7:0];
                    end else if (v[63:8] == '0) begin
                        head = HDR_U8;
                        nb   = REM_W'(1);
                    end else if (v[63:16] == '0) begin
                        head = HDR_U16;
                        nb   = REM_W'(2);
                    end else if (v[63:32] == '0) begin
                        head = HDR_U32;
                        nb   = REM_W'(4);
                    end else begin
                        head = HDR_U64;
                        nb   = REM_W'(8);
                    end
                end
            end
            ACT_F32: begin
                head = HDR_F32;
                data = {32'd0, v[31:0]};
                nb   = REM_W'(4);
            end
            ACT_F64: begin
                head = HDR_F64;
                data = v;
                nb   = REM_W'(8);
            end
            ACT_STR: begin
                data = {32'd0, c};
                if (c[31:5] == '0) begin
                    head = FIX_STR | {3'd0, c[4:0]};
                end else if (c[31:8] == '0) begin
                    head = HDR_STR8;
                    nb   = REM_W'(1);
                end else if (c[31:16] == '0) begin
                    head = HDR_STR16;
                    nb   = REM_W'(2);
                end else begin
                    head = HDR_STR32;
                    nb   = REM_W'(4);
                end
            end
            ACT_ARRAY, ACT_MAP: begin
                data = {32'd0, c};
                if (c[31:4] == '0) begin
                    head = ((i_in.action == ACT_ARRAY) ? FIX_ARRAY : FIX_MAP)
                           | {4'd0, c[3:0]};
                end else if (c[31:16] == '0) begin
                    head = (i_in.action == ACT_ARRAY) ? HDR_ARR16 : HDR_MAP16;
                    nb   = REM_W'(2);
                end else begin
                    head = (i_in.action == ACT_ARRAY) ? HDR_ARR32 : HDR_MAP32;
                    nb   = REM_W'(4);
                end
            end
            ACT_RAW: begin
                head = i_in.payload_byte;
            end
            default: begin
                head = 8'h00;
            end
        endcase
    end

    always_comb begin
        case (nb)
            REM_W'(1): aligned = {data[7:0], 56'd0};
            REM_W'(2): aligned = {data[15:0], 48'd0};
            REM_W'(4): aligned = {data[31:0], 32'd0};
            REM_W'(8): aligned = data;
            default:   aligned = 64'd0;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && (i_in.action <= ACT_RAW);
    assign o_cmd.sh   = {head, aligned};
    assign o_cmd.rem  = nb;

endmodule
`default_nettype wire

// ===== design/mve_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve_queue
// short command queue between classifier and serializer
// ----------------------------------------------------------------------------
module mve_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mve_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output mve_pkg::t_cmd       o_cmd
);
    import mve_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? r_wp + QAW'(1) : r_wp;
        n_rp  = do_pop ? r_rp + QAW'(1) : r_rp;
        n_cnt = r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/mve_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve_back
// shifts each command out one byte per beat through an output register
// ----------------------------------------------------------------------------
module mve_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire mve_pkg::t_cmd i_q_cmd,
    output logic               o_pop,
    mve_out_if.source          o_out
);
    import mve_pkg::*;

    logic [SH_W-1:0]  r_sh, n_sh;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_act, n_act;
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_ol, n_ol;
    logic             emit;
    logic             done;

    assign emit  = r_act && (!r_ov || o_out.ready);
    assign done  = emit && (r_rem == '0);
    assign o_pop = i_q_valid && (!r_act || done);

    always_comb begin
        n_sh  = r_sh;
        n_rem = r_rem;
        n_act = r_act;
        n_ov  = r_ov;
        n_ob  = r_ob;
        n_ol  = r_ol;
        if (emit) begin
            n_ov  = 1'b1;
            n_ob  = r_sh[SH_W-1 -: 8];
            n_ol  = (r_rem == '0);
            n_sh  = {r_sh[SH_W-9:0], 8'd0};
            n_rem = r_rem - REM_W'(1);
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
        if (o_pop) begin
            n_act = 1'b1;
            n_sh  = i_q_cmd.sh;
            n_rem = i_q_cmd.rem;
        end else if (done) begin
            n_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_ob  <= n_ob;
        r_ol  <= n_ol;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_ol;

endmodule
`default_nettype wire

// ===== design/mve_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mve_checker
// port level checks on the value encoder
// ----------------------------------------------------------------------------
module mve_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // a stalled beat keeps its byte and marker
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_out_last))
        else $error("output beat changed while stalled");

    // reset empties the serializer
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // reset empties the queue so input is open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // queue cannot be full while the output stays idle and nothing is pending
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(i_rst_n) |-> i_in_ready)
        else $error("input blocked with idle output");

endmodule

bind msgpack_value_encoder_core mve_checker u_mve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives typed values into the msgpack value encoder and checks every
// encoded beat, byte and last marker, against a local encoder model
// ----------------------------------------------------------------------------
module tb;
    import mve_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int N_ITEMS     = 230;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [63:0]      value;
        logic             flag;
        logic [31:0]      count;
        logic [7:0]       payload_byte;
    } t_value;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } t_enc_byte;

    logic i_clk;
    logic i_rst_n;

    mve_in_if  u_in_if ();
    mve_out_if u_out_if ();

    msgpack_value_encoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    t_value    value_q [$];
    t_enc_byte enc_bytes_q [$];
    t_value    cur_value;
    int        n_values_in;
    int        n_gen;
    int        err_cnt;
    int        quiet_cycles;
    logic      calm;

    assign calm = (n_values_in >= 100) && (n_values_in < 150);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // random magnitude of random width, often at the top or bottom of that width
    function automatic logic [63:0] rand_mag(input int max_w);
        int          w;
        logic [63:0] v;
        w = $urandom_range(max_w, 1);
        v = rand64() >> (64 - w);
        case ($urandom_range(3))
            0: v = {64{1'b1}} >> (64 - w);
            1: v = 64'd1 << (w - 1);
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_value(input logic [ACT_W-1:0] a, input logic [63:0] v,
                                      input logic f, input logic [31:0] c,
                                      input logic [7:0] p);
        t_value t;
        t.action       = a;
        t.value        = v;
        t.flag         = f;
        t.count        = c;
        t.payload_byte = p;
        value_q = {value_q, t};
        if (a <= ACT_RAW) n_gen++;
    endfunction

    function automatic void add_scalar();
        logic [63:0] v;
        v = rand_mag(64);
        case ($urandom_range(5))
            0: add_value(ACT_NIL, rand64(), rand_bit(), $urandom, rand_byte());
            1: add_value(ACT_BOOL, rand64(), rand_bit(), $urandom, rand_byte());
            2: add_value(ACT_INT, $urandom_range(1) ? ~v : v, rand_bit(), $urandom,
                         rand_byte());
            3: add_value(ACT_UINT, v, rand_bit(), $urandom, rand_byte());
            4: add_value(ACT_F32, rand64(), rand_bit(), $urandom, rand_byte());
            default: add_value(ACT_F64, rand64(), rand_bit(), $urandom, rand_byte());
        endcase
    endfunction

    function automatic void add_string();
        int          len;
        logic [31:0] c;
        len = $urandom_range(40);
        c = ($urandom_range(4) == 0) ? 32'(rand_mag(32)) : 32'(len);
        add_value(ACT_STR, rand64(), rand_bit(), c, rand_byte());
        if (c <= 40) begin
            for (int i = 0; i < c; i++)
                add_value(ACT_RAW, rand64(), rand_bit(), $urandom, rand_byte());
        end
    endfunction

    // header byte in hdr, then nb bytes of fld msb first
    function automatic int encode_msgpack(input t_value t, output logic [7:0] run [9]);
        logic [7:0]  hdr;
        logic [63:0] fld;
        logic [63:0] v;
        logic [31:0] c;
        int          nb;
        bit          emit;
        hdr  = 8'h00;
        fld  = 64'd0;
        nb   = 0;
        emit = 1'b1;
        v    = t.value;
        c    = t.count;
        if (t.action == ACT_INT && v[63]) begin
            if (v >= 64'hffff_ffff_ffff_ffe0) hdr = v[7:0];
            else if (v >= 64'hffff_ffff_ffff_ff80) begin hdr = HDR_I8;  nb = 1; end
            else if (v >= 64'hffff_ffff_ffff_8000) begin hdr = HDR_I16; nb = 2; end
            else if (v >= 64'hffff_ffff_8000_0000) begin hdr = HDR_I32; nb = 4; end
            else begin hdr = HDR_I64; nb = 8; end
            fld = v;
        end else if (t.action == ACT_INT || t.action == ACT_UINT) begin
            if (v <= 64'h7f) hdr = v[7:0];
            else if (v <= 64'hff) begin hdr = HDR_U8;  nb = 1; end
            else if (v <= 64'hffff) begin hdr = HDR_U16; nb = 2; end
            else if (v <= 64'hffff_ffff) begin hdr = HDR_U32; nb = 4; end
            else begin hdr = HDR_U64; nb = 8; end
            fld = v;
        end else begin
            case (t.action)
                ACT_NIL:  hdr = HDR_NIL;
                ACT_BOOL: hdr = t.flag ? HDR_TRUE : HDR_FALSE;
                ACT_F32: begin
                    hdr = HDR_F32;
                    fld = {32'd0, v[31:0]};
                    nb  = 4;
                end
                ACT_F64: begin
                    hdr = HDR_F64;
                    fld = v;
                    nb  = 8;
                end
                ACT_STR: begin
                    fld = {32'd0, c};
                    if (c <= 31) hdr = FIX_STR | c[7:0];
                    else if (c <= 32'hff) begin hdr = HDR_STR8; nb = 1; end
                    else if (c <= 32'hffff) begin hdr = HDR_STR16; nb = 2; end
                    else begin hdr = HDR_STR32; nb = 4; end
                end
                ACT_ARRAY, ACT_MAP: begin
                    fld = {32'd0, c};
                    if (c <= 15) hdr = ((t.action == ACT_MAP) ? FIX_MAP : FIX_ARRAY) | c[7:0];
                    else if (c <= 32'hffff) begin
                        hdr = (t.action == ACT_MAP) ? HDR_MAP16 : HDR_ARR16;
                        nb  = 2;
                    end else begin
                        hdr = (t.action == ACT_MAP) ? HDR_MAP32 : HDR_ARR32;
                        nb  = 4;
                    end
                end
                ACT_RAW: hdr = t.payload_byte;
                default: emit = 1'b0;
            endcase
        end
        run[0] = hdr;
        for (int i = 0; i < nb; i++) run[1+i] = 8'(fld >> ((nb - 1 - i) * 8));
        return emit ? 1 + nb : 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin : drv
        logic [7:0] run [9];
        int         n;
        t_enc_byte  eb;
        if (!i_rst_n) begin
            u_in_if.valid        <= 1'b0;
            u_in_if.action       <= ACT_NIL;
            u_in_if.value        <= 64'd0;
            u_in_if.flag         <= 1'b0;
            u_in_if.count        <= 32'd0;
            u_in_if.payload_byte <= 8'd0;
        end else begin
            if (u_in_if.valid && u_in_if.ready) begin
                n = encode_msgpack(cur_value, run);
                for (int i = 0; i < n; i++) begin
                    eb.out_byte = run[i];
                    eb.last     = (i == n - 1);
                    enc_bytes_q = {enc_bytes_q, eb};
                end
                n_values_in++;
            end
            if (!u_in_if.valid || u_in_if.ready) begin
                if (value_q.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                    cur_value = value_q.pop_front();
                    u_in_if.action       <= cur_value.action;
                    u_in_if.value        <= cur_value.value;
                    u_in_if.flag         <= cur_value.flag;
                    u_in_if.count        <= cur_value.count;
                    u_in_if.payload_byte <= cur_value.payload_byte;
                    u_in_if.valid        <= 1'b1;
                end else begin
                    u_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_enc_byte eb;
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                if (enc_bytes_q.size() == 0) begin
                    $error("out_byte: unexpected beat %02h last %0b",
                           u_out_if.out_byte, u_out_if.last);
                    err_cnt++;
                end else begin
                    eb = enc_bytes_q.pop_front();
                    if (u_out_if.out_byte !== eb.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", eb.out_byte, u_out_if.out_byte);
                        err_cnt++;
                    end
                    if (u_out_if.last !== eb.last) begin
                        $error("last: expected %0b, got %0b", eb.last, u_out_if.last);
                        err_cnt++;
                    end
                end
            end
            u_out_if.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int c;
        i_rst_n <= 1'b0;

        // directed: class boundaries, every action, unused codes
        add_value(ACT_NIL,   rand64(), 1'b1, $urandom, rand_byte());
        add_value(ACT_BOOL,  rand64(), 1'b1, $urandom, rand_byte());
        add_value(ACT_BOOL,  rand64(), 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'hffff_ffff_ffff_ffff, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'hffff_ffff_ffff_ffe0, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'hffff_ffff_ffff_ffdf, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'hffff_ffff_ffff_ff7f, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'hffff_ffff_ffff_7fff, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'h8000_0000_0000_0000, 1'b0, $urandom, rand_byte());
        add_value(ACT_INT,   64'h0000_0000_0000_0080, 1'b0, $urandom, rand_byte());
        add_value(ACT_UINT,  64'h0000_0000_0000_007f, 1'b0, $urandom, rand_byte());
        add_value(ACT_UINT,  64'h0000_0000_0000_0100, 1'b0, $urandom, rand_byte());
        add_value(ACT_UINT,  64'h0000_0000_0001_0000, 1'b0, $urandom, rand_byte());
        add_value(ACT_UINT,  64'hffff_ffff_ffff_ffff, 1'b0, $urandom, rand_byte());
        add_value(ACT_F32,   64'hdead_beef_3f80_0000, 1'b0, $urandom, rand_byte());
        add_value(ACT_F64,   64'hc009_21fb_5444_2d18, 1'b0, $urandom, rand_byte());
        add_value(ACT_STR,   rand64(), 1'b0, 32'd31, rand_byte());
        add_value(ACT_STR,   rand64(), 1'b0, 32'd32, rand_byte());
        add_value(ACT_STR,   rand64(), 1'b0, 32'd256, rand_byte());
        add_value(ACT_STR,   rand64(), 1'b0, 32'hffff_ffff, rand_byte());
        add_value(ACT_ARRAY, rand64(), 1'b0, 32'd16, rand_byte());
        add_value(ACT_MAP,   rand64(), 1'b0, 32'h0001_0000, rand_byte());
        add_value(ACT_RAW,   rand64(), 1'b0, $urandom, 8'hff);
        add_value(4'd10,     rand64(), 1'b1, $urandom, rand_byte());
        add_value(4'd15,     rand64(), 1'b1, $urandom, rand_byte());

        // random: mostly well-formed documents, some noise
        while (n_gen < N_ITEMS) begin
            r = $urandom_range(99);
            if (r < 15) begin
                add_string();
            end else if (r < 25) begin
                c = $urandom_range(6);
                add_value(ACT_ARRAY, rand64(), rand_bit(),
                          ($urandom_range(4) == 0) ? 32'(rand_mag(32)) : 32'(c), rand_byte());
                for (int i = 0; i < c; i++) add_scalar();
            end else if (r < 33) begin
                c = $urandom_range(4);
                add_value(ACT_MAP, rand64(), rand_bit(),
                          ($urandom_range(4) == 0) ? 32'(rand_mag(32)) : 32'(c), rand_byte());
                for (int i = 0; i < c; i++) begin
                    add_string();
                    add_scalar();
                end
            end else if (r < 95) begin
                add_scalar();
            end else if (r < 98) begin
                add_value(ACT_W'($urandom_range(15, 10)), rand64(), rand_bit(), $urandom,
                          rand_byte());
            end else begin
                add_value(ACT_RAW, rand64(), rand_bit(), $urandom, rand_byte());
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (value_q.size() != 0 || u_in_if.valid || enc_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
